// ----- hw/rtl/tdpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime table package
// Shared constants, result status codes and the command and status groups
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF  = 1024;
  localparam int unsigned NUMBER_WIDTH_DEF = 32;
  localparam int unsigned LIMIT_W          = 32;
  localparam int unsigned STATUS_W         = 3;
  localparam int unsigned FIRST_PRIME      = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_COMPOSITE    = 3'd0,
    ST_STORED       = 3'd1,
    ST_FULL         = 3'd2,
    ST_OVER_LIMIT   = 3'd3,
    ST_UNDETERMINED = 3'd4,
    ST_OUT_OF_ORDER = 3'd5
  } status_e;

  typedef struct packed {
    logic    accept;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    logic    div_start;
    logic    out_load;
    logic    commit;
    status_e out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic over_limit;
    logic out_of_order;
    logic div_done;
    logic p_gt_q;
    logic rem_zero;
    logic idx_last;
    logic table_full;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hw/rtl/tdpt_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime table divider
// Restoring divider that produces one quotient bit per cycle and holds the
// quotient and remainder after it finishes.
// ----------------------------------------------------------------------------
module tdpt_divider #(
  parameter int unsigned W = tdpt_pkg::NUMBER_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o,
  output logic [W-1:0] remainder_o
);

  localparam int unsigned CNTW = $clog2(W + 1);

  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    den_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic [W:0]      rem_sh;
  logic [W+1:0]    diff;
  logic            ge;

  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = ~diff[W+1];

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CNTW'(W);
      run_d = 1'b1;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end else begin
        rem_d = ge ? diff[W-1:0] : rem_sh[W-1:0];
        quo_d = {quo_q[W-2:0], ge};
        cnt_d = cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign done_o      = run_q && (cnt_q == '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- hw/rtl/tdpt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime table datapath
// Holds the candidate, the limit register, the prime memory, the table count,
// the divider and the result register.
// ----------------------------------------------------------------------------
module tdpt_datapath #(
  parameter int unsigned TABLE_DEPTH  = tdpt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tdpt_pkg::dp_cmd_t              cmd_i,
  output tdpt_pkg::dp_sts_t              sts_o,
  input  logic [NUMBER_WIDTH-1:0]        candidate_i,
  input  logic                           limit_we_i,
  input  logic [tdpt_pkg::LIMIT_W-1:0]   limit_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [tdpt_pkg::STATUS_W-1:0]  status_o,
  output logic [NUMBER_WIDTH-1:0]        divisor_o,
  output logic [CW-1:0]                  stored_count_o
);

  localparam int unsigned N     = NUMBER_WIDTH;
  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CMP_W = (N > tdpt_pkg::LIMIT_W) ? N : tdpt_pkg::LIMIT_W;

  logic [N-1:0]                 cand_q;
  logic [tdpt_pkg::LIMIT_W-1:0] limit_q;
  logic [AW-1:0]                idx_q;
  logic [CW-1:0]                count_q;
  logic [N-1:0]                 last_q;
  logic [N-1:0]                 mem [TABLE_DEPTH];
  logic [N-1:0]                 rdata_q;
  logic [N-1:0]                 p_now;
  logic [N-1:0]                 p_q;
  logic                         div_done;
  logic [N-1:0]                 quo;
  logic [N-1:0]                 rem;
  logic                         out_valid_q;
  tdpt_pkg::status_e            status_q;
  logic [N-1:0]                 divisor_q;
  logic [CW-1:0]                out_count_q;
  logic                         table_full;

  assign p_now      = (idx_q == '0) ? N'(tdpt_pkg::FIRST_PRIME) : rdata_q;
  assign table_full = (count_q == CW'(TABLE_DEPTH));

  tdpt_divider #(
    .W (N)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (cand_q),
    .divisor_i   (p_now),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !table_full) begin
      mem[count_q[AW-1:0]] <= cand_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cand_q <= candidate_i;
    end
    if (cmd_i.div_start) begin
      p_q <= p_now;
    end
    if (cmd_i.out_load) begin
      status_q    <= cmd_i.out_status;
      divisor_q   <= (cmd_i.out_status == tdpt_pkg::ST_COMPOSITE) ? p_q : '0;
      out_count_q <= cmd_i.commit ? (count_q + CW'(1)) : count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= '1;
      idx_q       <= '0;
      count_q     <= CW'(1);
      last_q      <= N'(tdpt_pkg::FIRST_PRIME);
      out_valid_q <= 1'b0;
    end else begin
      if (limit_we_i) begin
        limit_q <= limit_i;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.commit && !table_full) begin
        count_q <= count_q + CW'(1);
        last_q  <= cand_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.over_limit   = CMP_W'(cand_q) > CMP_W'(limit_q);
    sts_o.out_of_order = cand_q <= last_q;
    sts_o.div_done     = div_done;
    sts_o.p_gt_q       = p_q > quo;
    sts_o.rem_zero     = (rem == '0);
    sts_o.idx_last     = ((CW'(idx_q) + CW'(1)) == count_q);
    sts_o.table_full   = table_full;
    sts_o.out_free     = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign divisor_o      = divisor_q;
  assign stored_count_o = out_count_q;

endmodule

// ----- hw/rtl/tdpt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime table controller
// Sequences the checks, the walk over stored primes and the hand-off of the
// result word.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tdpt_pkg::dp_sts_t sts_i,
  output tdpt_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_READ   = 7'b0000100,
    S_LOAD   = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_EVAL   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  tdpt_pkg::status_e st_q, st_d;

  always_comb begin
    state_d          = state_q;
    st_d             = st_q;
    cmd_o            = '0;
    cmd_o.out_status = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.over_limit) begin
          st_d    = tdpt_pkg::ST_OVER_LIMIT;
          state_d = S_FINISH;
        end else if (sts_i.out_of_order) begin
          st_d    = tdpt_pkg::ST_OUT_OF_ORDER;
          state_d = S_FINISH;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.p_gt_q) begin
          st_d    = sts_i.table_full ? tdpt_pkg::ST_FULL : tdpt_pkg::ST_STORED;
          state_d = S_FINISH;
        end else if (sts_i.rem_zero) begin
          st_d    = tdpt_pkg::ST_COMPOSITE;
          state_d = S_FINISH;
        end else if (sts_i.idx_last) begin
          st_d    = tdpt_pkg::ST_UNDETERMINED;
          state_d = S_FINISH;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_READ;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.commit   = (st_q == tdpt_pkg::ST_STORED);
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= tdpt_pkg::ST_COMPOSITE;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/trial_division_prime_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime table
// Tests rising candidates against a table of stored primes, one divide per
// stored prime tried, and appends each proven prime while the table has room.
// A rejected candidate gives its word after the limit and order checks alone;
// a tested one goes through the bit-serial divider once for each prime tried.
// The input stays stalled until the result word of the last candidate is loaded.
// Reset: the table holds only 2, the limit is all ones; no clearing pass.
// ----------------------------------------------------------------------------
module trial_division_prime_table #(
  parameter int unsigned TABLE_DEPTH  = tdpt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          candidate_limit_we_i,
  input  logic [tdpt_pkg::LIMIT_W-1:0]  candidate_limit_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [NUMBER_WIDTH-1:0]       candidate_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tdpt_pkg::STATUS_W-1:0] status_o,
  output logic [NUMBER_WIDTH-1:0]       divisor_o,
  output logic [CW-1:0]                 stored_count_o
);

  tdpt_pkg::dp_cmd_t cmd;
  tdpt_pkg::dp_sts_t sts;

  tdpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tdpt_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .candidate_i    (candidate_i),
    .limit_we_i     (candidate_limit_we_i),
    .limit_i        (candidate_limit_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .divisor_o      (divisor_o),
    .stored_count_o (stored_count_o)
  );

endmodule

// ----- hw/rtl/tdpt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime table checker
// Port-level assertions on the input handshake and the result words, bound to the top level.
// ----------------------------------------------------------------------------
module tdpt_checker #(
  parameter int unsigned TABLE_DEPTH  = tdpt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tdpt_pkg::STATUS_W-1:0] status_o,
  input logic [NUMBER_WIDTH-1:0]       divisor_o,
  input logic [CW-1:0]                 stored_count_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input not stalled after a word was taken.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(divisor_o) && $stable(stored_count_o))
    else $error("Stalled result word changed.");

  a_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == tdpt_pkg::ST_COMPOSITE) == (divisor_o != '0)))
    else $error("Divisor does not match the status.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stored_count_o != '0) && (stored_count_o <= CW'(TABLE_DEPTH)))
    else $error("Stored count out of range.");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tdpt_pkg::ST_FULL)
      |-> (stored_count_o == CW'(TABLE_DEPTH)))
    else $error("Table full reported with room left.");

endmodule

bind trial_division_prime_table tdpt_checker #(
  .TABLE_DEPTH  (TABLE_DEPTH),
  .NUMBER_WIDTH (NUMBER_WIDTH)
) u_tdpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .divisor_o      (divisor_o),
  .stored_count_o (stored_count_o)
);

// ----- tb/trial_division_prime_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime table testbench
// Feeds rising candidates, mostly primes so that the table fills, with noise
// mixed in, under random gaps and stalls on both sides. Every result word is
// checked against an in-bench model of the prime table and the limit.
// ----------------------------------------------------------------------------
module trial_division_prime_table_tb;

  localparam int unsigned DEPTH       = tdpt_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned NW          = tdpt_pkg::NUMBER_WIDTH_DEF;
  localparam int unsigned CW          = $clog2(DEPTH + 1);
  localparam int unsigned LW          = tdpt_pkg::LIMIT_W;
  localparam int unsigned HALF_PERIOD = 4;
  localparam logic [NW-1:0] ALL_ONES  = '1;

  typedef struct {
    tdpt_pkg::status_e status;
    logic [NW-1:0]     divisor;
    logic [CW-1:0]     count;
  } verdict_t;

  logic                          clk_i                = 1'b0;
  logic                          rst_ni               = 1'b0;
  logic                          candidate_limit_we_i = 1'b0;
  logic [LW-1:0]                 candidate_limit_i    = '0;
  logic                          in_valid_i           = 1'b0;
  logic                          in_stall_o;
  logic [NW-1:0]                 candidate_i          = '0;
  logic                          out_valid_o;
  logic                          out_stall_i          = 1'b0;
  logic [tdpt_pkg::STATUS_W-1:0] status_o;
  logic [NW-1:0]                 divisor_o;
  logic [CW-1:0]                 stored_count_o;

  logic [NW-1:0]      cand_backlog[$];
  verdict_t           verdict_q[$];
  verdict_t           oldest_verdict;
  logic [NW-1:0]      prime_tab[DEPTH];
  int unsigned        prime_cnt;
  logic [LW-1:0]      limit_model;
  logic [NW-1:0]      frontier;
  int unsigned        primes_fed;
  int unsigned        cands_taken   = 0;
  int unsigned        verdicts_seen = 0;
  int unsigned        fail_count    = 0;
  int unsigned        send_gap      = 0;
  int unsigned        stall_left    = 0;
  int unsigned        added;
  logic               hold_off      = 1'b0;

  trial_division_prime_table uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .candidate_limit_we_i (candidate_limit_we_i),
    .candidate_limit_i    (candidate_limit_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .candidate_i          (candidate_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_o             (status_o),
    .divisor_o            (divisor_o),
    .stored_count_o       (stored_count_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic verdict_t predict_verdict(input logic [NW-1:0] cand);
    verdict_t      v;
    int unsigned   i;
    logic [NW-1:0] p;
    bit            settled;
    v.status  = tdpt_pkg::ST_UNDETERMINED;
    v.divisor = '0;
    if (cand > limit_model) begin
      v.status = tdpt_pkg::ST_OVER_LIMIT;
    end else if (cand <= prime_tab[prime_cnt-1]) begin
      v.status = tdpt_pkg::ST_OUT_OF_ORDER;
    end else begin
      settled = 1'b0;
      for (i = 0; i < prime_cnt && !settled; i++) begin
        p = prime_tab[i];
        if (p > cand / p) begin
          settled = 1'b1;
          if (prime_cnt < DEPTH) begin
            prime_tab[prime_cnt] = cand;
            prime_cnt++;
            v.status = tdpt_pkg::ST_STORED;
          end else begin
            v.status = tdpt_pkg::ST_FULL;
          end
        end else if (cand % p == 0) begin
          settled   = 1'b1;
          v.status  = tdpt_pkg::ST_COMPOSITE;
          v.divisor = p;
        end
      end
    end
    v.count = prime_cnt[CW-1:0];
    return v;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic bit is_prime(input longint unsigned x);
    longint unsigned d;
    if (x < 2) return 1'b0;
    if (x % 2 == 0) return x == 2;
    for (d = 3; d * d <= x; d += 2) begin
      if (x % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [NW-1:0] next_prime_above(input logic [NW-1:0] x);
    longint unsigned y;
    y = longint'(x) + 1;
    while (!is_prime(y)) y++;
    return y[NW-1:0];
  endfunction

  task automatic write_limit(input logic [LW-1:0] value);
    @(posedge clk_i);
    candidate_limit_we_i <= 1'b1;
    candidate_limit_i    <= value;
    @(posedge clk_i);
    candidate_limit_we_i <= 1'b0;
    limit_model = value;
  endtask

  task automatic wait_idle();
    while (cand_backlog.size() != 0 || in_valid_i || verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly the next prime past the frontier, so the table keeps growing.
  task automatic add_random_item();
    int unsigned   roll;
    logic [NW-1:0] cand;
    roll = $urandom_range(0, 99);
    if (roll < 88) begin
      frontier = next_prime_above(frontier);
      cand     = frontier;
      primes_fed++;
    end else if (roll < 93) begin
      frontier = frontier + 2 * $urandom_range(1, 8);
      cand     = frontier;
    end else if (roll < 95) begin
      cand = frontier + 1 + 2 * $urandom_range(0, 3);
    end else if (roll < 98) begin
      cand = $urandom_range(frontier, 0);
    end else if (limit_model == ALL_ONES) begin
      cand = $urandom | 32'h8000_0000;
    end else begin
      cand = $urandom_range(ALL_ONES, limit_model + 1);
    end
    cand_backlog.push_back(cand);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        verdict_q.push_back(predict_verdict(candidate_i));
        cands_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap--;
        end else if (cand_backlog.size() != 0) begin
          in_valid_i  <= 1'b1;
          candidate_i <= cand_backlog.pop_front();
          send_gap = ((cands_taken / 64) % 5 == 2) ? 0 : idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected word, status %0d divisor %0d count %0d",
                   $time, status_o, divisor_o, stored_count_o);
          fail_count++;
        end else begin
          oldest_verdict = verdict_q.pop_front();
          if (status_o !== oldest_verdict.status) begin
            $display("%0t: status expected %0d, actual %0d",
                     $time, oldest_verdict.status, status_o);
            fail_count++;
          end
          if (divisor_o !== oldest_verdict.divisor) begin
            $display("%0t: divisor expected %0d, actual %0d",
                     $time, oldest_verdict.divisor, divisor_o);
            fail_count++;
          end
          if (stored_count_o !== oldest_verdict.count) begin
            $display("%0t: stored_count expected %0d, actual %0d",
                     $time, oldest_verdict.count, stored_count_o);
            fail_count++;
          end
        end
        verdicts_seen++;
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if ((verdicts_seen / 64) % 5 != 4 && $urandom_range(0, 7) == 0) begin
        stall_left = idle_len();
      end
      out_stall_i <= hold_off || (stall_left != 0);
    end
  end

  // Hold the result side off long enough for the block to back up.
  initial begin
    while (cands_taken < 60) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #(64'd320_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) prime_tab[i] = '0;
    prime_tab[0] = tdpt_pkg::FIRST_PRIME;
    prime_cnt    = 1;
    limit_model  = ALL_ONES;
    primes_fed   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_limit('0);
    cand_backlog = '{32'd0, 32'd1, ALL_ONES};
    wait_idle();

    write_limit(32'd1000);
    cand_backlog = '{32'd9, 32'd3, 32'd4, 32'd2, 32'd3, 32'd25, 32'd5, 32'd25,
                     32'd7, 32'd49, 32'd1001, 32'd1000};
    wait_idle();

    write_limit(ALL_ONES);
    cand_backlog = '{ALL_ONES, 32'hFFFF_FFFE, 32'hFFFF_FFFB, 32'd11, 32'd13};
    frontier = 32'd13;
    repeat (700) add_random_item();
    wait_idle();

    write_limit(32'd9000 + $urandom_range(0, 1000));
    added = 0;
    while (primes_fed < 1040 || added < 400) begin
      add_random_item();
      added++;
    end
    wait_idle();
    repeat (40) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
